[rtl/core/detection_leader_clustering_unit_assert.svh]
// Assertion macros for the clustering block.
`ifndef DETECTION_LEADER_CLUSTERING_UNIT_ASSERT_SVH
`define DETECTION_LEADER_CLUSTERING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlc assertion failed");

`define DLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlc assertion failed");

`else

`define DLC_ASSERT_IMP(label, ante, cons)

`define DLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/dlc_pkg.sv]
package dlc_pkg;

    localparam int MAX_GROUPS = 32;
    localparam int GIDX_W     = $clog2(MAX_GROUPS);
    localparam int GCNT_W     = $clog2(MAX_GROUPS + 1);
    localparam int POS_W      = 16;
    localparam int CNT_W      = 16;
    localparam int COL_W      = 8;
    localparam int MSQ_W      = 2 * POS_W;
    localparam int DIST_W     = MSQ_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_MARGIN  = 2'd2;

    localparam logic [15:0]      MERGE_DISTANCE_RST = 16'd1024;
    localparam logic [15:0]      REPORT_COUNT_RST   = 16'd20;
    localparam logic [7:0]       YELLOW_MARGIN_RST  = 8'd15;
    localparam logic [MSQ_W-1:0] MERGE_SQ_RST       = 32'd1048576;

    localparam logic [1:0] ACT_MERGE = 2'd0;
    localparam logic [1:0] ACT_NEW   = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_RED    = 3'd1;
    localparam logic [2:0] CLS_GREEN  = 3'd2;
    localparam logic [2:0] CLS_BLUE   = 3'd3;
    localparam logic [2:0] CLS_YELLOW = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
    } in_word_t;

    typedef struct packed {
        logic [4:0]              group_index;
        logic [1:0]              action;
        logic                    report_raised;
        logic signed [POS_W-1:0] group_x;
        logic signed [POS_W-1:0] group_y;
        logic signed [POS_W-1:0] group_z;
        logic [2:0]              color_class;
        logic [15:0]             report_number;
    } out_word_t;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } group_entry_t;

    typedef struct packed {
        logic              busy;
        logic              found;
        logic [GIDX_W-1:0] best_idx;
        logic [DIST_W-1:0] best_dist;
    } near_status_t;

    function automatic logic [2:0] color_class_f(
        input logic [COL_W-1:0] r,
        input logic [COL_W-1:0] g,
        input logic [COL_W-1:0] b,
        input logic [COL_W-1:0] margin
    );
        logic [COL_W-1:0] diff;
        logic [2:0]       cls;
        diff = (r > g) ? r - g : g - r;
        if (r > g && r > b)
        begin
            cls = (diff < margin) ? CLS_YELLOW : CLS_RED;
        end
        else if (g > r && g > b)
        begin
            cls = (diff < margin) ? CLS_YELLOW : CLS_GREEN;
        end
        else if (b > r && b > g)
        begin
            cls = CLS_BLUE;
        end
        else
        begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

    function automatic logic signed [POS_W-1:0] half_sum_f(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        return s[POS_W:1];
    endfunction

endpackage

[rtl/core/dlc_group_mem.sv]
module dlc_group_mem
    import dlc_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [GIDX_W-1:0] waddr,
    input  group_entry_t      wdata,
    input  logic              re,
    input  logic [GIDX_W-1:0] raddr,
    output group_entry_t      rdata
);

    group_entry_t mem [MAX_GROUPS];
    group_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dlc_near_unit.sv]
module dlc_near_unit
    import dlc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    in_valid,
    input  logic [GIDX_W-1:0]       in_idx,
    input  logic signed [POS_W-1:0] gx,
    input  logic signed [POS_W-1:0] gy,
    input  logic signed [POS_W-1:0] px,
    input  logic signed [POS_W-1:0] py,
    output near_status_t            status
);

    logic                    v1_reg, v2_reg, v3_reg;
    logic [GIDX_W-1:0]       idx1_reg, idx2_reg, idx3_reg;
    logic signed [POS_W:0]   dx_reg, dy_reg;
    logic [MSQ_W-1:0]        sqx_reg, sqy_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    found_reg;
    logic [DIST_W-1:0]       best_reg;
    logic [GIDX_W-1:0]       best_idx_reg;
    logic signed [MSQ_W+1:0] prod_x, prod_y;
    logic                    take;

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign take   = v3_reg && (!found_reg || dist_reg < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (clear)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= {gx[POS_W-1], gx} - {px[POS_W-1], px};
        dy_reg   <= {gy[POS_W-1], gy} - {py[POS_W-1], py};
        idx1_reg <= in_idx;
        sqx_reg  <= prod_x[MSQ_W-1:0];
        sqy_reg  <= prod_y[MSQ_W-1:0];
        idx2_reg <= idx1_reg;
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        idx3_reg <= idx2_reg;
        if (take)
        begin
            best_reg     <= dist_reg;
            best_idx_reg <= idx3_reg;
        end
    end

    always_comb
    begin
        status.busy      = v1_reg || v2_reg || v3_reg;
        status.found     = found_reg;
        status.best_idx  = best_idx_reg;
        status.best_dist = best_reg;
    end

endmodule

[rtl/core/detection_leader_clustering_unit.sv]
// Detection leader clustering unit.
// Input channel (in_valid / in_stall / in_data) takes one detection word:
// x, y, z position and average color. Output channel (out_valid /
// out_stall / out_data) gives exactly one result word per detection: the
// group merged into, opened or (when the table is full) nearest, the
// action, the group position after the update and any report raised.
// Configuration is a write port (cfg_write_en, cfg_index, cfg_data);
// write it only while no detection is in flight.
// Sequence: ST_SCAN reads one group a cycle from the group memory into a
// pipelined squared-distance unit, ST_DRAIN waits for the unit to empty
// and picks the action, ST_FETCH reads the chosen group when the detection
// merges or is dropped, and ST_COMMIT registers the result and writes the
// merged or new group back, one read-modify-write; an empty table skips the
// scan. The next detection is taken in the cycle after the result is
// registered; none is taken while the previous one is still in progress.
// A detection can be accepted while the previous result waits in the
// output register; a stalled receiver holds the result and the block
// waits before committing the next one.
// Reset empties the group table, zeroes the report counter and loads the
// configuration defaults. No clearing pass is needed.
`include "detection_leader_clustering_unit_assert.svh"

module detection_leader_clustering_unit
    import dlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_COMMIT
    } state_t;

    state_t            state_reg, state_next;
    in_word_t          in_reg, in_next;
    logic [GCNT_W-1:0] groups_reg, groups_next;
    logic [CNT_W-1:0]  rep_cnt_reg, rep_cnt_next;
    logic [GIDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic              scan_rvalid_reg, scan_rvalid_next;
    logic [1:0]        act_reg, act_next;
    logic [GIDX_W-1:0] sel_idx_reg, sel_idx_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg, out_data_next;

    logic [15:0]       md_reg;
    logic [15:0]       rc_reg;
    logic [7:0]        ym_reg;
    logic [MSQ_W-1:0]  msq_reg;

    logic              in_accept;
    logic              emit_ok;
    logic              commit;
    near_status_t      near;
    group_entry_t      rd_entry;
    group_entry_t      wr_entry;
    logic              mem_we;
    logic              mem_re;
    logic [GIDX_W-1:0] mem_raddr;
    out_word_t         res;
    logic [CNT_W-1:0]  cnt_new;
    logic              cnt_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_ok   = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_COMMIT) && emit_ok;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg  <= MERGE_DISTANCE_RST;
            rc_reg  <= REPORT_COUNT_RST;
            ym_reg  <= YELLOW_MARGIN_RST;
            msq_reg <= MERGE_SQ_RST;
        end
        else
        begin
            msq_reg <= md_reg * md_reg;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MERGE_DISTANCE: md_reg <= cfg_data;
                    CFG_REPORT_COUNT:   rc_reg <= cfg_data;
                    CFG_YELLOW_MARGIN:  ym_reg <= cfg_data[7:0];
                    default:            ;
                endcase
            end
        end
    end

    dlc_group_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (sel_idx_reg),
        .wdata (wr_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    dlc_near_unit u_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (in_accept),
        .in_valid (scan_rvalid_reg),
        .in_idx   (scan_idx_reg - GIDX_W'(1)),
        .gx       (rd_entry.x),
        .gy       (rd_entry.y),
        .px       (in_reg.pos_x),
        .py       (in_reg.pos_y),
        .status   (near)
    );

    assign mem_re    = (state_reg == ST_SCAN) || (state_reg == ST_FETCH);
    assign mem_raddr = (state_reg == ST_SCAN) ? scan_idx_reg : sel_idx_reg;
    assign mem_we    = commit && (act_reg != ACT_DROP);

    // result and write-back entry
    always_comb
    begin
        cnt_sat = (rd_entry.count == CNT_MAX);
        cnt_new = cnt_sat ? rd_entry.count : rd_entry.count + 1'b1;

        res.group_index   = 5'(sel_idx_reg);
        res.action        = act_reg;
        res.report_raised = 1'b0;
        res.color_class   = CLS_NONE;
        res.report_number = '0;
        res.group_x       = rd_entry.x;
        res.group_y       = rd_entry.y;
        res.group_z       = rd_entry.z;
        wr_entry.count    = 16'd1;
        wr_entry.x        = in_reg.pos_x;
        wr_entry.y        = in_reg.pos_y;
        wr_entry.z        = in_reg.pos_z;

        case (act_reg)
            ACT_MERGE:
            begin
                wr_entry.count = cnt_new;
                wr_entry.x     = half_sum_f(rd_entry.x, in_reg.pos_x);
                wr_entry.y     = half_sum_f(rd_entry.y, in_reg.pos_y);
                wr_entry.z     = half_sum_f(rd_entry.z, in_reg.pos_z);
                res.group_x    = wr_entry.x;
                res.group_y    = wr_entry.y;
                res.group_z    = wr_entry.z;
                if (!cnt_sat && cnt_new == rc_reg)
                begin
                    res.report_raised = 1'b1;
                    res.color_class   = color_class_f(in_reg.red, in_reg.green,
                                                      in_reg.blue, ym_reg);
                    res.report_number = rep_cnt_reg;
                end
            end
            ACT_NEW:
            begin
                res.group_x = in_reg.pos_x;
                res.group_y = in_reg.pos_y;
                res.group_z = in_reg.pos_z;
            end
            default:
            begin
                res.group_x = rd_entry.x;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        in_next          = in_reg;
        groups_next      = groups_reg;
        rep_cnt_next     = rep_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        act_next         = act_reg;
        sel_idx_next     = sel_idx_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && out_stall;
        scan_rvalid_next = (state_reg == ST_SCAN);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    in_next       = in_data;
                    scan_idx_next = '0;
                    state_next    = (groups_reg == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (GCNT_W'(scan_idx_reg) == groups_reg - GCNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!scan_rvalid_reg && !near.busy)
                begin
                    if (near.found && near.best_dist < {1'b0, msq_reg})
                    begin
                        act_next     = ACT_MERGE;
                        sel_idx_next = near.best_idx;
                        state_next   = ST_FETCH;
                    end
                    else if (groups_reg < GCNT_W'(MAX_GROUPS))
                    begin
                        act_next     = ACT_NEW;
                        sel_idx_next = GIDX_W'(groups_reg);
                        state_next   = ST_COMMIT;
                    end
                    else
                    begin
                        act_next     = ACT_DROP;
                        sel_idx_next = near.best_idx;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    if (res.report_raised)
                    begin
                        rep_cnt_next = rep_cnt_reg + 1'b1;
                    end
                    if (act_reg == ACT_NEW)
                    begin
                        groups_next = groups_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            groups_reg      <= '0;
            rep_cnt_reg     <= '0;
            scan_rvalid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            act_reg         <= ACT_NEW;
            sel_idx_reg     <= '0;
            scan_idx_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            groups_reg      <= groups_next;
            rep_cnt_reg     <= rep_cnt_next;
            scan_rvalid_reg <= scan_rvalid_next;
            out_valid_reg   <= out_valid_next;
            act_reg         <= act_next;
            sel_idx_reg     <= sel_idx_next;
            scan_idx_reg    <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        out_data_reg <= out_data_next;
    end

    `DLC_ASSERT_IMP(a_groups_bound, 1'b1, groups_reg <= GCNT_W'(MAX_GROUPS))
    `DLC_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, GCNT_W'(scan_idx_reg) < groups_reg)
    `DLC_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != ST_IDLE)
    `DLC_ASSERT_NEXT(a_report_step, commit && res.report_raised, rep_cnt_reg == CNT_W'($past(rep_cnt_reg) + 1'b1))
    `DLC_ASSERT_NEXT(a_open_step, commit && act_reg == ACT_NEW, groups_reg == GCNT_W'($past(groups_reg) + 1'b1))

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import dlc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the group table and registers
    logic signed [15:0] grp_x [MAX_GROUPS];
    logic signed [15:0] grp_y [MAX_GROUPS];
    logic signed [15:0] grp_z [MAX_GROUPS];
    logic [15:0]        grp_cnt [MAX_GROUPS];
    int                 groups_used = 0;
    logic [15:0]        report_seq = '0;
    logic [15:0]        merge_dist = MERGE_DISTANCE_RST;
    logic [15:0]        report_at = REPORT_COUNT_RST;
    logic [7:0]         yellow_margin_q = YELLOW_MARGIN_RST;
    out_word_t          cluster_outcomes[$];

    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 60;
    int hold_left = 0;

    detection_leader_clustering_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic signed [15:0] floor_half(logic signed [15:0] a,
                                                      logic signed [15:0] b);
        int s;
        s = int'(a) + int'(b);
        return 16'(s >>> 1);
    endfunction

    function automatic logic [2:0] color_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [7:0] diff;
        diff = (r > g) ? r - g : g - r;
        if (r > g && r > b)
        begin
            return (diff < yellow_margin_q) ? CLS_YELLOW : CLS_RED;
        end
        if (g > r && g > b)
        begin
            return (diff < yellow_margin_q) ? CLS_YELLOW : CLS_GREEN;
        end
        if (b > r && b > g)
        begin
            return CLS_BLUE;
        end
        return CLS_NONE;
    endfunction

    function automatic void cluster_detection(in_word_t d);
        out_word_t res;
        longint    best;
        longint    d2;
        longint    dx;
        longint    dy;
        int        near;
        bit        found;
        res   = '0;
        best  = 0;
        near  = 0;
        found = 1'b0;
        for (int i = 0; i < groups_used; i++)
        begin
            dx = longint'(grp_x[i]) - longint'($signed(d.pos_x));
            dy = longint'(grp_y[i]) - longint'($signed(d.pos_y));
            d2 = dx * dx + dy * dy;
            if (!found || d2 < best)
            begin
                best  = d2;
                near  = i;
                found = 1'b1;
            end
        end
        if (found && best < longint'(merge_dist) * longint'(merge_dist))
        begin
            res.action = ACT_MERGE;
            if (grp_cnt[near] != CNT_MAX)
            begin
                grp_cnt[near] = grp_cnt[near] + 16'd1;
                if (grp_cnt[near] == report_at)
                begin
                    res.report_raised = 1'b1;
                    res.color_class   = color_of(d.red, d.green, d.blue);
                    res.report_number = report_seq;
                    report_seq        = report_seq + 16'd1;
                end
            end
            grp_x[near] = floor_half(grp_x[near], d.pos_x);
            grp_y[near] = floor_half(grp_y[near], d.pos_y);
            grp_z[near] = floor_half(grp_z[near], d.pos_z);
        end
        else if (groups_used < MAX_GROUPS)
        begin
            res.action     = ACT_NEW;
            near           = groups_used;
            grp_x[near]    = d.pos_x;
            grp_y[near]    = d.pos_y;
            grp_z[near]    = d.pos_z;
            grp_cnt[near]  = 16'd1;
            groups_used++;
        end
        else
        begin
            res.action = ACT_DROP;
        end
        res.group_index = 5'(near);
        res.group_x     = grp_x[near];
        res.group_y     = grp_y[near];
        res.group_z     = grp_z[near];
        cluster_outcomes.insert(cluster_outcomes.size(), res);
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cluster_outcomes.size() == 0)
            begin
                $display("%0t: unexpected word expected none got %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = cluster_outcomes.pop_front();
                compare_field("group_index", want.group_index, out_data.group_index);
                compare_field("action", want.action, out_data.action);
                compare_field("report_raised", want.report_raised, out_data.report_raised);
                compare_field("group_x", want.group_x, out_data.group_x);
                compare_field("group_y", want.group_y, out_data.group_y);
                compare_field("group_z", want.group_z, out_data.group_z);
                compare_field("color_class", want.color_class, out_data.color_class);
                compare_field("report_number", want.report_number, out_data.report_number);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [15:0] clamp_pos(int v);
        if (v > 32767)
        begin
            v = 32767;
        end
        else if (v < -32768)
        begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(11))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            5: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_word_t make_detection(int x, int y, int z, int r, int g, int b);
        in_word_t w;
        w.pos_x = 16'(x);
        w.pos_y = 16'(y);
        w.pos_z = 16'(z);
        w.red   = 8'(r);
        w.green = 8'(g);
        w.blue  = 8'(b);
        return w;
    endfunction

    function automatic in_word_t noise_detection();
        in_word_t w;
        w.pos_x = 16'($urandom);
        w.pos_y = 16'($urandom);
        w.pos_z = 16'($urandom);
        w.red   = rand_level();
        w.green = rand_level();
        w.blue  = rand_level();
        return w;
    endfunction

    function automatic in_word_t near_detection();
        in_word_t w;
        int       g;
        int       span;
        w = noise_detection();
        if ($urandom_range(3) == 0)
        begin
            w.green = w.red ^ 8'($urandom_range(15));
        end
        if (groups_used > 0)
        begin
            g    = $urandom_range(groups_used - 1);
            span = merge_dist / 2;
            if ($urandom_range(7) == 0)
            begin
                // land right on the merge boundary
                w.pos_x = clamp_pos(int'(grp_x[g]) + int'(merge_dist));
                w.pos_y = grp_y[g];
            end
            else
            begin
                w.pos_x = clamp_pos(int'(grp_x[g]) + int'($urandom_range(2 * span)) - span);
                w.pos_y = clamp_pos(int'(grp_y[g]) + int'($urandom_range(2 * span)) - span);
            end
        end
        return w;
    endfunction

    function automatic int lowest_count();
        int low;
        low = 65535;
        for (int i = 0; i < groups_used; i++)
        begin
            if (int'(grp_cnt[i]) < low)
            begin
                low = grp_cnt[i];
            end
        end
        return (groups_used == 0) ? 1 : low;
    endfunction

    task automatic send_detection(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        cluster_detection(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (cluster_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input int md, input int rc, input int ym);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MERGE_DISTANCE;
        cfg_data     <= 16'(md);
        @(posedge clk);
        cfg_index    <= CFG_REPORT_COUNT;
        cfg_data     <= 16'(rc);
        @(posedge clk);
        // upper byte must be ignored
        cfg_index    <= CFG_YELLOW_MARGIN;
        cfg_data     <= {8'($urandom), 8'(ym)};
        @(posedge clk);
        cfg_index    <= CFG_UNUSED;
        cfg_data     <= 16'($urandom);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        merge_dist      = 16'(md);
        report_at       = 16'(rc);
        yellow_margin_q = 8'(ym);
    endtask

    task automatic test_directed();
        // empty table, then just inside and exactly at the merge distance
        send_detection(make_detection(0, 0, 0, 0, 0, 0));
        send_detection(make_detection(1023, 0, -7, 255, 255, 255));
        send_detection(make_detection(int'(grp_x[0]) + 1024, 0, 3, 7, 9, 8));
        send_detection(make_detection(32767, 32767, 32767, 255, 0, 0));
        send_detection(make_detection(-32768, -32768, -32768, 0, 255, 0));
        send_detection(make_detection(32767, -32768, 0, 0, 0, 255));
        send_detection(make_detection(-32768, 32767, -1, 128, 128, 128));
        // floored half-sums on negative values
        send_detection(make_detection(-32767, -32768, 32767, 1, 2, 3));
        send_detection(make_detection(32766, 32767, -32768, 3, 2, 1));
        send_detection(make_detection(10000, 10000, 5, 10, 20, 30));
        send_detection(make_detection(10000, 14000, -5, 30, 20, 10));
        load_config(3000, 2, 15);
        // equidistant pair: first group wins; reports of each color
        send_detection(make_detection(10000, 12000, 0, 200, 190, 10));
        send_detection(make_detection(10000, 14001, 1, 10, 200, 20));
        send_detection(make_detection(int'(grp_x[1]) + 60, 50, 2, 0, 0, 200));
        send_detection(make_detection(32767, -32767, 3, 255, 255, 0));
        send_detection(make_detection(-32767, 32767, 4, 200, 10, 10));
        send_detection(make_detection(int'(grp_x[0]), int'(grp_y[0]), 5, 50, 50, 50));
        load_config(3000, 1, 15);
        send_detection(make_detection(-20000, 5000, 6, 90, 10, 10));
        send_detection(make_detection(-20000, 5001, 7, 90, 10, 10));
        load_config(0, 20, 15);
        send_detection(make_detection(int'(grp_x[0]), int'(grp_y[0]), 8, 1, 1, 1));
    endtask

    task automatic test_register_extremes();
        load_config(65535, 1, 0);
        repeat (12) send_detection(near_detection());
        load_config(0, 65535, 255);
        repeat (45) send_detection(noise_detection());
    endtask

    task automatic test_random_traffic();
        int md_pick [9] = '{3000, 1500, 65535, 6000, 800, 0, 12000, 2000, 4000};
        int rc;
        int ym;
        for (int k = 0; k < 9; k++)
        begin
            if (k == 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 8;
            end
            else if (k == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            rc = lowest_count() + $urandom_range(1, 3);
            if (rc > 65535)
            begin
                rc = 65535;
            end
            if (k == 4)
            begin
                rc = 1;
            end
            else if (k == 7)
            begin
                rc = 65535;
            end
            ym = (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(255);
            load_config(md_pick[k], rc, ym);
            repeat (50)
            begin
                if ($urandom_range(99) < 80)
                begin
                    send_detection(near_detection());
                end
                else
                begin
                    send_detection(noise_detection());
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        load_config(5000, lowest_count() + 2, 40);
        hold_left = 300;
        repeat (20) send_detection(near_detection());
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dlc_pkg.sv
rtl/core/dlc_group_mem.sv
rtl/core/dlc_near_unit.sv
rtl/core/detection_leader_clustering_unit.sv
verif/tb_top.sv
